### hw/rtl/rlphe_pkg.sv
package rlphe_pkg;

	// command codes
	typedef enum logic [1:0] {
		CMD_STRING = 2'd0,
		CMD_LIST   = 2'd1,
		CMD_NUMBER = 2'd2,
		CMD_SIZE   = 2'd3
	} rlphe_cmd_t;

	// prefix bases and limits
	localparam logic [7:0]  STR_SHORT_BASE  = 8'h80;
	localparam logic [7:0]  STR_LONG_BASE   = 8'hb7;
	localparam logic [7:0]  LIST_SHORT_BASE = 8'hc0;
	localparam logic [7:0]  LIST_LONG_BASE  = 8'hf7;
	localparam logic [7:0]  NUM_BASE        = 8'h80;
	localparam logic [7:0]  SINGLE_MAX      = 8'h7f;
	localparam logic [23:0] SHORT_LEN_MAX   = 24'd55;

	localparam int MAX_BYTES = 5;
	localparam int IDX_W     = $clog2(MAX_BYTES);
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);

	typedef struct packed {
		rlphe_cmd_t  cmd;
		logic [23:0] field_length;
		logic [7:0]  first_byte;
		logic [31:0] number_value;
	} rlphe_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [24:0] encoded_size;
		logic        last;
	} rlphe_out_t;

	// one classified command: bytes in emission order
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic [24:0]               size;
	} rlphe_job_t;

endpackage

### hw/rtl/rlphe_front.sv
module rlphe_front import rlphe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  rlphe_in_t  cmd_data,
	output logic       push_valid,
	input  logic       push_ready,
	output rlphe_job_t push_job
);

	logic       valid_s1;
	rlphe_job_t job_s1;
	rlphe_job_t job_d;
	logic       advance;

	always_comb begin
		logic [23:0] len;
		logic [31:0] num;
		logic [1:0]  nlen;
		logic [2:0]  nnum;
		logic        single;
		logic        long_len;
		logic [7:0]  short_base;
		logic [7:0]  long_base;

		len        = cmd_data.field_length;
		num        = cmd_data.number_value;
		single     = (len == 24'd1) && (cmd_data.first_byte <= SINGLE_MAX);
		long_len   = len > SHORT_LEN_MAX;
		short_base = (cmd_data.cmd == CMD_LIST) ? LIST_SHORT_BASE : STR_SHORT_BASE;
		long_base  = (cmd_data.cmd == CMD_LIST) ? LIST_LONG_BASE : STR_LONG_BASE;

		if (len[23:16] != 8'd0) begin
			nlen = 2'd3;
		end else if (len[15:8] != 8'd0) begin
			nlen = 2'd2;
		end else begin
			nlen = 2'd1;
		end

		if (num[31:24] != 8'd0) begin
			nnum = 3'd4;
		end else if (num[23:16] != 8'd0) begin
			nnum = 3'd3;
		end else if (num[15:8] != 8'd0) begin
			nnum = 3'd2;
		end else begin
			nnum = 3'd1;
		end

		job_d = '0;
		unique case (cmd_data.cmd)
			CMD_STRING, CMD_LIST: begin
				if (cmd_data.cmd == CMD_STRING && single) begin
					job_d.count = '0;
				end else if (!long_len) begin
					job_d.bytes[0] = short_base + len[7:0];
					job_d.count    = CNT_W'(1);
				end else begin
					job_d.bytes[0] = long_base + {6'd0, nlen};
					unique case (nlen)
						2'd1: begin
							job_d.bytes[1] = len[7:0];
						end
						2'd2: begin
							job_d.bytes[1] = len[15:8];
							job_d.bytes[2] = len[7:0];
						end
						default: begin
							job_d.bytes[1] = len[23:16];
							job_d.bytes[2] = len[15:8];
							job_d.bytes[3] = len[7:0];
						end
					endcase
					job_d.count = CNT_W'(nlen) + CNT_W'(1);
				end
			end
			CMD_NUMBER: begin
				if (num == 32'd0) begin
					job_d.count = '0;
				end else if (num <= {24'd0, SINGLE_MAX}) begin
					job_d.bytes[0] = num[7:0];
					job_d.count    = CNT_W'(1);
				end else begin
					job_d.bytes[0] = NUM_BASE + {5'd0, nnum};
					unique case (nnum)
						3'd1: begin
							job_d.bytes[1] = num[7:0];
						end
						3'd2: begin
							job_d.bytes[1] = num[15:8];
							job_d.bytes[2] = num[7:0];
						end
						3'd3: begin
							job_d.bytes[1] = num[23:16];
							job_d.bytes[2] = num[15:8];
							job_d.bytes[3] = num[7:0];
						end
						default: begin
							job_d.bytes[1] = num[31:24];
							job_d.bytes[2] = num[23:16];
							job_d.bytes[3] = num[15:8];
							job_d.bytes[4] = num[7:0];
						end
					endcase
					job_d.count = CNT_W'(nnum) + CNT_W'(1);
				end
			end
			CMD_SIZE: begin
				job_d.count = CNT_W'(1);
				if (single) begin
					job_d.size = 25'd1;
				end else if (!long_len) begin
					job_d.size = 25'd1 + {1'b0, len};
				end else begin
					job_d.size = 25'd1 + 25'(nlen) + {1'b0, len};
				end
			end
			default: begin
				job_d = '0;
			end
		endcase
	end

	// commands with nothing to emit retire here without a queue slot
	assign advance    = !valid_s1 || (job_s1.count == '0) || push_ready;
	assign cmd_stall  = !advance;
	assign push_valid = valid_s1 && (job_s1.count != '0);
	assign push_job   = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

### hw/rtl/rlphe_queue.sv
module rlphe_queue import rlphe_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  rlphe_job_t push_job,
	output logic       head_valid,
	input  logic       pop,
	output rlphe_job_t head_job
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	rlphe_job_t        slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q != FILL_W'(DEPTH);
	assign head_valid = fill_q != '0;
	assign head_job   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hw/rtl/rlphe_back.sv
module rlphe_back import rlphe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  rlphe_job_t head_job,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rlphe_out_t rsp_data
);

	logic             busy_q;
	rlphe_job_t       job_q;
	logic [IDX_W-1:0] idx_q;
	logic             rsp_valid_q;
	rlphe_out_t       rsp_data_q;
	logic             out_load;
	logic             last_now;
	logic             is_size;

	assign out_load = busy_q && (!rsp_valid_q || !rsp_stall);
	assign last_now = CNT_W'(idx_q) + CNT_W'(1) == job_q.count;
	assign is_size  = job_q.size != '0;
	assign pop      = head_valid && (!busy_q || (out_load && last_now));

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				busy_q <= !last_now;
				idx_q  <= idx_q + IDX_W'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (out_load) begin
			rsp_data_q.out_byte     <= is_size ? 8'd0 : job_q.bytes[idx_q];
			rsp_data_q.encoded_size <= job_q.size;
			rsp_data_q.last         <= last_now;
		end
	end

endmodule

### hw/rtl/rlp_header_encoder_core.sv
// channel | direction | handshake            | payload
// cmd     | in        | cmd_valid, cmd_stall | cmd_data (rlphe_in_t)
// rsp     | out       | rsp_valid, rsp_stall | rsp_data (rlphe_out_t)
//
// one response byte per cycle while rsp_stall is low, and a command emits 1 to 5 bytes
// (number of header bytes); commands with nothing to emit retire in the front stage
// first byte path: front register, queue slot, back job register, output register
// the front stage keeps taking commands while the back stage serializes earlier ones
// arst_n clears valid flags, queue pointers and the serializer; payload is not reset
// rsp_stall holds the output register; the queue fills, then cmd_stall rises
module rlp_header_encoder_core import rlphe_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  rlphe_in_t  cmd_data,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rlphe_out_t rsp_data
);

	// classified commands between front and back
	logic       push_valid;
	logic       push_ready;
	rlphe_job_t push_job;
	logic       head_valid;
	rlphe_job_t head_job;
	logic       pop;

	// front: decode command, build header bytes, byte count and size
	rlphe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// short queue decouples command intake from byte output
	rlphe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.head_valid (head_valid),
		.pop        (pop),
		.head_job   (head_job)
	);

	// back: serialize bytes into the output register, mark the last one
	rlphe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

endmodule

### tb/sv/rlp_header_encoder_core_test.sv
module rlp_header_encoder_core_test import rlphe_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// generous bound, far above the slowest legal run
	localparam int CYCLE_LIMIT = 200000;
	// receiver hold-off length, long enough to back the block up into cmd_stall
	localparam int HOLD_CYCLES = 90;

	// a queued command plus whether the sender drains the block before offering it
	typedef struct {
		rlphe_in_t item;
		bit        drain_first;
	} pending_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	rlphe_in_t  cmd_data = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rlphe_out_t rsp_data;

	pending_cmd_t cmd_backlog[$];
	rlphe_out_t   header_bytes_q[$];

	bit failed = 1'b0;
	bit cmd_taken = 1'b0;
	int cmd_count = 0;
	int cycles = 0;

	// sender side state
	int gap_left = 0;
	int send_mode_left = 0;
	bit send_calm = 1'b0;

	// receiver side state
	int stall_left = 0;
	int hold_left = 0;
	int next_hold_at = 50;
	int rcv_mode_left = 0;
	bit rcv_calm = 1'b0;

	rlp_header_encoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// mostly no idle, some short idles, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// number of big-endian bytes needed to carry a payload length
	function automatic int length_bytes(input logic [23:0] len);
		if (len > 24'hffff) return 3;
		if (len > 24'hff) return 2;
		return 1;
	endfunction

	// string or list prefix, bytes right-aligned with the first one on top
	function automatic void header_seq(input logic [7:0] short_base, input logic [7:0] long_base,
			input logic [23:0] len, output logic [39:0] seq, output int cnt);
		logic [7:0] pre;
		int nl;
		nl = length_bytes(len);
		if (len <= SHORT_LEN_MAX) begin
			pre = short_base + len[7:0];
			seq = 40'(pre);
			cnt = 1;
		end else begin
			pre = long_base + 8'(nl);
			seq = (40'(pre) << (8 * nl)) | 40'(len);
			cnt = nl + 1;
		end
	endfunction

	// works out the bytes one command emits and queues them in order
	function automatic void encode_rlp(input rlphe_in_t c);
		logic [39:0] seq;
		logic [24:0] size;
		logic [7:0]  pre;
		int          cnt;
		int          nb;
		bit          single;
		rlphe_out_t  r;
		seq = '0;
		size = '0;
		cnt = 0;
		// a lone byte up to 0x7f is its own encoding
		single = (c.field_length == 24'd1) && (c.first_byte <= SINGLE_MAX);
		case (c.cmd)
			CMD_STRING: begin
				if (!single)
					header_seq(STR_SHORT_BASE, STR_LONG_BASE, c.field_length, seq, cnt);
			end
			CMD_LIST: begin
				header_seq(LIST_SHORT_BASE, LIST_LONG_BASE, c.field_length, seq, cnt);
			end
			CMD_NUMBER: begin
				// strip leading zero bytes, zero itself emits nothing
				nb = 4;
				while (nb > 1 && c.number_value[8*(nb-1) +: 8] == 8'h00)
					nb--;
				if (c.number_value == 32'd0) begin
					cnt = 0;
				end else if (nb == 1 && c.number_value <= 32'(SINGLE_MAX)) begin
					seq = 40'(c.number_value);
					cnt = 1;
				end else begin
					pre = NUM_BASE + 8'(nb);
					seq = (40'(pre) << (8 * nb)) | 40'(c.number_value);
					cnt = nb + 1;
				end
			end
			CMD_SIZE: begin
				if (single)
					size = 25'd1;
				else if (c.field_length <= SHORT_LEN_MAX)
					size = 25'd1 + 25'(c.field_length);
				else
					size = 25'(1 + length_bytes(c.field_length)) + 25'(c.field_length);
				cnt = 1;
			end
			default: ;
		endcase
		for (int i = 0; i < cnt; i++) begin
			r.out_byte = seq[8*(cnt-1-i) +: 8];
			r.encoded_size = size;
			r.last = (i == cnt - 1);
			header_bytes_q.push_back(r);
		end
	endfunction

	function automatic void add_item(input rlphe_cmd_t c, input logic [23:0] len,
			input logic [7:0] fb, input logic [31:0] num, input bit drain);
		pending_cmd_t p;
		p.item.cmd = c;
		p.item.field_length = len;
		p.item.first_byte = fb;
		p.item.number_value = num;
		p.drain_first = drain;
		cmd_backlog.push_back(p);
	endfunction

	// stimulus, reset and end of run
	initial begin
		logic [23:0] len;
		logic [31:0] num;
		int          nb;

		// directed: length boundaries, single-byte case, number widths, size query
		add_item(CMD_STRING, 24'd0, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_STRING, 24'd1, 8'h7f, $urandom, 1'b0);
		add_item(CMD_STRING, 24'd1, 8'h80, $urandom, 1'b0);
		add_item(CMD_STRING, 24'd55, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_STRING, 24'd56, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_STRING, 24'd256, 8'h00, $urandom, 1'b0);
		add_item(CMD_STRING, 24'd65536, 8'hff, $urandom, 1'b0);
		add_item(CMD_STRING, 24'hffffff, 8'hff, 32'hffffffff, 1'b0);
		add_item(CMD_LIST, 24'd0, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_LIST, 24'd1, 8'h00, $urandom, 1'b0);
		add_item(CMD_LIST, 24'd55, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_LIST, 24'd56, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_LIST, 24'hffffff, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_NUMBER, 24'($urandom), 8'($urandom), 32'd0, 1'b0);
		add_item(CMD_NUMBER, 24'($urandom), 8'($urandom), 32'h7f, 1'b0);
		add_item(CMD_NUMBER, 24'($urandom), 8'($urandom), 32'h80, 1'b0);
		add_item(CMD_NUMBER, 24'($urandom), 8'($urandom), 32'h100, 1'b0);
		add_item(CMD_NUMBER, 24'($urandom), 8'($urandom), 32'h10000, 1'b0);
		add_item(CMD_NUMBER, 24'hffffff, 8'hff, 32'hffffffff, 1'b0);
		add_item(CMD_SIZE, 24'd1, 8'h00, $urandom, 1'b0);
		add_item(CMD_SIZE, 24'd1, 8'hff, $urandom, 1'b0);
		add_item(CMD_SIZE, 24'd55, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_SIZE, 24'd56, 8'($urandom), $urandom, 1'b0);
		add_item(CMD_SIZE, 24'hffffff, 8'($urandom), $urandom, 1'b0);

		// random: lengths spread over every prefix form, numbers over every width
		for (int i = 0; i < 190; i++) begin
			case ($urandom_range(0, 7))
				0: len = 24'($urandom_range(0, 2));
				1: len = 24'($urandom_range(3, 55));
				2: len = 24'($urandom_range(54, 57));
				3: len = 24'($urandom_range(56, 255));
				4: len = 24'($urandom_range(256, 65535));
				5: len = 24'($urandom_range(65536, 16777215));
				default: len = 24'($urandom);
			endcase
			nb = $urandom_range(0, 4);
			num = (nb == 0) ? 32'd0 : ($urandom >> (8 * (4 - nb)));
			// one transaction midway waits for the block to drain
			add_item(rlphe_cmd_t'($urandom_range(0, 3)), len, 8'($urandom_range(0, 255)), num,
				i == 95);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every command transaction taken, then every byte back
		while (cmd_backlog.size() > 0 || cmd_valid)
			@(negedge clk);
		while (header_bytes_q.size() > 0)
			@(negedge clk);
		// watch for stray bytes after the last expected one
		repeat (20) @(negedge clk);
		if (!failed) begin
			$display("rlp_header_encoder_core_test passed");
		end else begin
			$display("rlp_header_encoder_core_test failed");
		end
		$finish;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rlp_header_encoder_core_test failed");
			$finish;
		end
	end

	// command driver: one transaction at a time from the backlog, with random gaps
	always @(negedge clk) begin : drive_cmd
		pending_cmd_t p;
		logic         v_next;
		rlphe_in_t    d_next;
		if (arst_n) begin
			v_next = cmd_valid;
			d_next = cmd_data;
			// alternate stretches with and without idling
			if (send_mode_left == 0) begin
				send_calm = ($urandom_range(0, 2) == 0);
				send_mode_left = $urandom_range(40, 160);
			end else begin
				send_mode_left--;
			end
			// held payload only moves on once the transaction went through
			if (cmd_valid && cmd_taken)
				v_next = 1'b0;
			if (!v_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0 &&
						!(cmd_backlog[0].drain_first && header_bytes_q.size() > 0)) begin
					p = cmd_backlog.pop_front();
					d_next = p.item;
					v_next = 1'b1;
					gap_left = send_calm ? 0 : idle_len();
				end
			end
			cmd_valid <= v_next;
			cmd_data <= d_next;
		end
	end

	// response side backpressure, plus long hold-offs that fill the block
	always @(negedge clk) begin : drive_rsp_stall
		logic st;
		int   n;
		if (arst_n) begin
			if (rcv_mode_left == 0) begin
				rcv_calm = ($urandom_range(0, 2) == 0);
				rcv_mode_left = $urandom_range(40, 160);
			end else begin
				rcv_mode_left--;
			end
			if (cmd_count >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at += 120;
			end
			if (hold_left > 0) begin
				st = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				st = 1'b1;
				stall_left--;
			end else begin
				n = rcv_calm ? 0 : idle_len();
				st = (n > 0);
				stall_left = (n > 0) ? n - 1 : 0;
			end
			rsp_stall <= st;
		end
	end

	// monitor: predict on each command transaction, check each response transaction
	always @(posedge clk) begin : watch
		rlphe_out_t want;
		if (arst_n) begin
			cmd_taken <= cmd_valid && !cmd_stall;
			if (cmd_valid && !cmd_stall) begin
				encode_rlp(cmd_data);
				cmd_count <= cmd_count + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (header_bytes_q.size() == 0) begin
					$error("unexpected response transaction: out_byte %02h encoded_size %0d last %0b",
						rsp_data.out_byte, rsp_data.encoded_size, rsp_data.last);
					failed = 1'b1;
				end else begin
					want = header_bytes_q.pop_front();
					if (rsp_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h", want.out_byte,
							rsp_data.out_byte);
						failed = 1'b1;
					end
					if (rsp_data.encoded_size !== want.encoded_size) begin
						$error("encoded_size: expected %0d, actual %0d", want.encoded_size,
							rsp_data.encoded_size);
						failed = 1'b1;
					end
					if (rsp_data.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, rsp_data.last);
						failed = 1'b1;
					end
				end
			end
		end
	end

endmodule
